// File: rtl/mrkl_pkg.sv
package mrkl_pkg;

   localparam int MAX_LEAVES = 1024;
   localparam int LEAF_W = $clog2(MAX_LEAVES + 1);
   localparam int NODE_W = $clog2(MAX_LEAVES);
   localparam int ADDR_W = NODE_W + 2;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [511:0] PAD_BLOCK = {32'h80000000, 448'b0, 32'h00000400};

   typedef struct packed {
      logic start;
      logic init;
   } sha_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sha_stat_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + {4'b0, nib}) : (8'h57 + {4'b0, nib});
   endfunction

   function automatic logic [127:0] hex64(input logic [63:0] word);
      logic [127:0] res;
      res = '0;
      for (int k = 0; k < 16; k++) begin
         res[127 - 8 * k -: 8] = hex_char(word[63 - 4 * k -: 4]);
      end
      return res;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/mrkl_sha256_core.sv
module mrkl_sha256_core
   import mrkl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sha_cmd_type  cmd,
   input  logic [511:0] block,
   output sha_stat_type stat,
   output logic [255:0] digest
);

   typedef enum logic [2:0] {
      C_IDLE = 3'b001,
      C_RUN  = 3'b010,
      C_FIN  = 3'b100
   } core_state_type;

   core_state_type state_ff;
   logic [5:0]  round_ff;
   logic        done_ff;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];

   logic [31:0] t1, t2, w_new, s0, s1;

   always_comb begin
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
           + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(round_ff) + w_ff[0];
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (cmd.start) begin
                  for (int k = 0; k < 8; k++) begin
                     h_ff[k] <= cmd.init ? H_INIT[k] : h_ff[k];
                     v_ff[k] <= cmd.init ? H_INIT[k] : h_ff[k];
                  end
                  for (int k = 0; k < 16; k++) begin
                     w_ff[k] <= block[511 - 32 * k -: 32];
                  end
                  round_ff <= '0;
                  state_ff <= C_RUN;
               end
            end
            C_RUN: begin
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               for (int k = 0; k < 15; k++) begin
                  w_ff[k] <= w_ff[k + 1];
               end
               w_ff[15] <= w_new;
               round_ff <= round_ff + 6'd1;
               if (round_ff == 6'd63) begin
                  state_ff <= C_FIN;
               end
            end
            C_FIN: begin
               for (int k = 0; k < 8; k++) begin
                  h_ff[k] <= h_ff[k] + v_ff[k];
               end
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = done_ff;
   assign digest = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4], h_ff[5], h_ff[6], h_ff[7]};

endmodule

// File: rtl/merkle_root_sha256_hex_core.sv
// Leaf digests arrive as one 64-bit beat per cycle while busy is low, four beats per leaf,
// and the beat with req_last_leaf starts the build; busy then stays high until the root is
// out. Each parent takes three SHA-256 compressions (64 rounds, the final add and the done
// strobe each) on one shared round unit, plus level setup and store reads and writes. A tree
// of n leaves needs n - 1 parents plus one more for every level of more than one node with
// an odd node count. The root leaves as four rsp_valid beats on consecutive cycles, most
// significant word first, and the receiver cannot stall them.
module merkle_root_sha256_hex_core
   import mrkl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_leaf_word,
   input  logic        req_last_leaf,
   output logic        rsp_valid,
   output logic [63:0] rsp_root_word,
   output logic        rsp_word_last,
   output logic        rsp_leaves_dropped
);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_FILL = 7'b0000010,
      S_LVL  = 7'b0000100,
      S_RD   = 7'b0001000,
      S_HASH = 7'b0010000,
      S_WR   = 7'b0100000,
      S_OUT  = 7'b1000000
   } seq_state_type;

   seq_state_type state_ff;
   logic [LEAF_W-1:0] leaves_ff, count_ff, idx_ff, next_ff;
   logic [1:0]        wil_ff, fill_ff;
   logic [NODE_W-1:0] fill_leaf_ff;
   logic              ovf_ff;
   logic [2:0]        cnt_ff;
   logic [1:0]        phase_ff;
   logic              cap_v_ff;
   logic [1:0]        cap_idx_ff;
   logic [127:0]      blk_ff [4];
   logic              rsp_valid_ff, rsp_last_ff;

   logic [63:0]       mem [1 << ADDR_W];
   logic [63:0]       rd_ff;
   logic              we;
   logic [ADDR_W-1:0] wa, ra;
   logic [63:0]       wd;

   sha_cmd_type       cmd;
   sha_stat_type      stat;
   logic [511:0]      block;
   logic [255:0]      digest;

   logic              accept, stored;
   logic [LEAF_W-1:0] leaves_next, right_node, node, idx_plus2;

   assign accept = start && (state_ff == S_IDLE);
   assign stored = (leaves_ff < LEAF_W'(MAX_LEAVES));
   assign leaves_next = leaves_ff
                        + LEAF_W'(stored && (wil_ff == 2'd3 || req_last_leaf));
   assign right_node = ((idx_ff + LEAF_W'(1)) < count_ff) ? idx_ff + LEAF_W'(1) : idx_ff;
   assign node = (phase_ff == 2'd0) ? idx_ff : right_node;
   assign idx_plus2 = idx_ff + LEAF_W'(2);

   always_comb begin
      we = 1'b0;
      wa = {fill_leaf_ff, fill_ff};
      wd = '0;
      ra = {node[NODE_W-1:0], cnt_ff[1:0]};
      unique case (state_ff)
         S_IDLE: begin
            we = accept && stored;
            wa = {leaves_ff[NODE_W-1:0], wil_ff};
            wd = req_leaf_word;
         end
         S_FILL: begin
            we = 1'b1;
         end
         S_WR: begin
            we = 1'b1;
            wa = {next_ff[NODE_W-1:0], cnt_ff[1:0]};
            wd = digest[255 - 64 * cnt_ff[1:0] -: 64];
         end
         S_OUT: begin
            ra = {{NODE_W{1'b0}}, cnt_ff[1:0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   always_comb begin
      cmd.start = 1'b0;
      cmd.init  = 1'b0;
      block = {blk_ff[0], blk_ff[1], blk_ff[2], blk_ff[3]};
      if (state_ff == S_RD && cnt_ff == 3'd5) begin
         cmd.start = 1'b1;
         cmd.init  = (phase_ff == 2'd0);
      end else if (state_ff == S_HASH && stat.done && phase_ff == 2'd1) begin
         cmd.start = 1'b1;
         block = PAD_BLOCK;
      end
   end

   mrkl_sha256_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .block  (block),
      .stat   (stat),
      .digest (digest)
   );

   always_ff @(posedge clock) begin
      if (cap_v_ff) begin
         blk_ff[cap_idx_ff] <= hex64(rd_ff);
      end
      cap_idx_ff  <= cnt_ff[1:0];
      rsp_last_ff <= (cnt_ff == 3'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         leaves_ff    <= '0;
         wil_ff       <= '0;
         ovf_ff       <= 1'b0;
         cap_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         phase_ff     <= '0;
      end else begin
         cap_v_ff     <= (state_ff == S_RD) && (cnt_ff < 3'd4);
         rsp_valid_ff <= (state_ff == S_OUT) && (cnt_ff < 3'd4);
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  leaves_ff <= leaves_next;
                  wil_ff    <= wil_ff + 2'd1;
                  if (!stored) begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last_leaf) begin
                     count_ff     <= leaves_next;
                     idx_ff       <= '0;
                     next_ff      <= '0;
                     fill_ff      <= wil_ff + 2'd1;
                     fill_leaf_ff <= leaves_ff[NODE_W-1:0];
                     state_ff     <= (stored && wil_ff != 2'd3) ? S_FILL : S_LVL;
                  end
               end
            end
            S_FILL: begin
               fill_ff <= fill_ff + 2'd1;
               if (fill_ff == 2'd3) begin
                  state_ff <= S_LVL;
               end
            end
            S_LVL: begin
               cnt_ff   <= '0;
               phase_ff <= 2'd0;
               state_ff <= (count_ff > LEAF_W'(1)) ? S_RD : S_OUT;
            end
            S_RD: begin
               if (cnt_ff == 3'd5) begin
                  state_ff <= S_HASH;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_HASH: begin
               cnt_ff <= '0;
               if (stat.done) begin
                  unique case (phase_ff)
                     2'd0: begin
                        phase_ff <= 2'd1;
                        state_ff <= S_RD;
                     end
                     2'd1: phase_ff <= 2'd2;
                     default: state_ff <= S_WR;
                  endcase
               end
            end
            S_WR: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd3) begin
                  if (idx_plus2 >= count_ff) begin
                     count_ff <= next_ff + LEAF_W'(1);
                     idx_ff   <= '0;
                     next_ff  <= '0;
                  end else begin
                     idx_ff  <= idx_plus2;
                     next_ff <= next_ff + LEAF_W'(1);
                  end
                  state_ff <= S_LVL;
               end
            end
            S_OUT: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd4) begin
                  leaves_ff <= '0;
                  wil_ff    <= '0;
                  ovf_ff    <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_root_word      = rd_ff;
   assign rsp_word_last      = rsp_last_ff;
   assign rsp_leaves_dropped = ovf_ff;

endmodule

// File: tb/merkle_root_sha256_hex_core_tb.sv
`timescale 1ns / 100ps

module merkle_root_sha256_hex_core_tb;

   localparam int LEAF_CAP = 1024;

   typedef struct {
      logic [63:0] word;
      logic        last;
   } leaf_beat_type;

   typedef struct {
      logic [63:0] word;
      logic        last;
      logic        dropped;
   } root_beat_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_leaf_word;
   logic        req_last_leaf;
   logic        rsp_valid;
   logic [63:0] rsp_root_word;
   logic        rsp_word_last;
   logic        rsp_leaves_dropped;

   merkle_root_sha256_hex_core uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_leaf_word(req_leaf_word),
      .req_last_leaf(req_last_leaf),
      .rsp_valid(rsp_valid),
      .rsp_root_word(rsp_root_word),
      .rsp_word_last(rsp_word_last),
      .rsp_leaves_dropped(rsp_leaves_dropped)
   );

   leaf_beat_type leaf_beats[$];
   root_beat_type root_beats[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;

   logic [63:0] node_words[4*LEAF_CAP];
   int          leaf_count = 0;
   int          word_pos = 0;
   logic        leaf_overflow = 1'b0;
   logic [31:0] chain[8];

   localparam logic [31:0] KTAB[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV[8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic sha_block(input logic [511:0] blk);
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
      for (int i = 16; i < 64; i++) begin
         w[i] = w[i - 16] + w[i - 7]
              + (ror(w[i - 15], 7) ^ ror(w[i - 15], 18) ^ (w[i - 15] >> 3))
              + (ror(w[i - 2], 17) ^ ror(w[i - 2], 19) ^ (w[i - 2] >> 10));
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
   endtask

   function automatic logic [511:0] node_text(int n);
      logic [511:0] res;
      logic [3:0]   nib;
      for (int k = 0; k < 64; k++) begin
         nib = node_words[n * 4 + k / 16][63 - 4 * (k % 16) -: 4];
         res[511 - 8 * k -: 8] = (nib < 10) ? 8'h30 + nib : 8'h61 + nib - 8'd10;
      end
      return res;
   endfunction

   task automatic hash_nodes(input int l, input int r, input int d);
      for (int i = 0; i < 8; i++) chain[i] = IV[i];
      sha_block(node_text(l));
      sha_block(node_text(r));
      sha_block({32'h80000000, 448'b0, 32'h00000400});
      for (int i = 0; i < 4; i++) node_words[d * 4 + i] = {chain[2 * i], chain[2 * i + 1]};
   endtask

   task automatic absorb_leaf_word(input logic [63:0] word, input logic last);
      int            n;
      int            nxt;
      root_beat_type rb;
      if (leaf_count < LEAF_CAP) begin
         node_words[leaf_count * 4 + word_pos] = word;
         if (last)
            for (int i = word_pos + 1; i < 4; i++) node_words[leaf_count * 4 + i] = '0;
         if (word_pos == 3 || last) leaf_count++;
      end else begin
         leaf_overflow = 1'b1;
      end
      word_pos = (word_pos + 1) % 4;
      if (last) begin
         n = leaf_count;
         while (n > 1) begin
            nxt = 0;
            for (int i = 0; i < n; i += 2) begin
               hash_nodes(i, (i + 1 < n) ? i + 1 : i, nxt);
               nxt++;
            end
            n = nxt;
         end
         for (int i = 0; i < 4; i++) begin
            rb.word = node_words[i];
            rb.last = (i == 3);
            rb.dropped = leaf_overflow;
            root_beats.insert(root_beats.size(), rb);
         end
         leaf_count = 0;
         word_pos = 0;
         leaf_overflow = 1'b0;
      end
   endtask

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_leaf_word <= '0;
         req_last_leaf <= 1'b0;
      end else begin
         if (start && !busy) begin
            absorb_leaf_word(req_leaf_word, req_last_leaf);
            void'(leaf_beats.pop_front());
         end
         if (leaf_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            start <= 1'b1;
            req_leaf_word <= leaf_beats[0].word;
            req_last_leaf <= leaf_beats[0].last;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (root_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected root beat %h", rsp_root_word);
         end else begin
            if (rsp_root_word !== root_beats[0].word || rsp_word_last !== root_beats[0].last
                || rsp_leaves_dropped !== root_beats[0].dropped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("root beat mismatch: expected %h %b %b, got %h %b %b",
                           root_beats[0].word, root_beats[0].last, root_beats[0].dropped,
                           rsp_root_word, rsp_word_last, rsp_leaves_dropped);
            end
            void'(root_beats.pop_front());
         end
      end
   end

   task automatic queue_beat(input logic [63:0] word, input logic last);
      leaf_beat_type b;
      b.word = word;
      b.last = last;
      leaf_beats.insert(leaf_beats.size(), b);
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_tree(input int leaves, input int last_pos);
      for (int l = 0; l < leaves; l++)
         for (int w = 0; w < 4; w++) begin
            if (l == leaves - 1 && w == last_pos) begin
               queue_beat(rand_word(), 1'b1);
               return;
            end
            queue_beat(rand_word(), 1'b0);
         end
   endtask

   task automatic drain();
      while (leaf_beats.size() > 0 || root_beats.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      int sent;
      int nl;
      reset = 1'b1;
      start = 1'b0;
      req_leaf_word = '0;
      req_last_leaf = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      queue_beat('1, 1'b0); queue_beat('1, 1'b0); queue_beat('1, 1'b0); queue_beat('1, 1'b1);
      queue_beat('0, 1'b0); queue_beat('0, 1'b0); queue_beat('0, 1'b0); queue_beat('0, 1'b1);
      push_tree(2, 3);
      push_tree(3, 3);
      push_tree(1, 0);
      push_tree(2, 1);
      push_tree(2, 2);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 0 : (ph == 1) ? 75 : 36;
         sent = 0;
         while (sent < 55) begin
            nl = ($urandom_range(9) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 6);
            push_tree(nl, ($urandom_range(4) == 0) ? $urandom_range(3) : 3);
            sent += 4 * nl;
         end
         drain();
      end

      if (mismatches == 0 && root_beats.size() == 0) begin
         $display("merkle_root_sha256_hex_core_tb passed");
      end else begin
         $display("merkle_root_sha256_hex_core_tb failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("merkle_root_sha256_hex_core_tb failed");
      $finish;
   end

endmodule
